### sv/mft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mft_pkg
// Shared types and constants for the motor feedback multiturn tracker.
// ----------------------------------------------------------------------------
package mft_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CURRENT_MODE    = 2'd0;
  localparam logic [1:0] CFG_READ_ERROR      = 2'd1;
  localparam logic [1:0] CFG_OFFLINE_TIMEOUT = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  RST_CURRENT_MODE    = 8'd161;
  localparam logic [7:0]  RST_READ_ERROR      = 8'd154;
  localparam logic [15:0] RST_OFFLINE_TIMEOUT = 16'd100;

  // Input commands.
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // While fewer frames than this are counted, turn unwrap starts from a zero count.
  localparam logic [31:0] WARMUP_FRAMES = 32'd50;

  // Encoder jump of half a turn or more counts as a wrap.
  localparam logic signed [16:0] HALF_TURN_POS = 17'sd32768;
  localparam logic signed [16:0] HALF_TURN_NEG = -17'sd32768;

  typedef struct packed {
    logic        warmup_clear;
    logic [15:0] turn;
    logic [15:0] prev_enc;
    logic [15:0] new_enc;
  } mft_unwrap_req_t;

endpackage
`default_nettype wire

### sv/mft_unwrap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mft_unwrap
// Turn counter update from two successive single-turn encoder readings.
// ----------------------------------------------------------------------------
module mft_unwrap (
  input  wire mft_pkg::mft_unwrap_req_t req,
  output logic [15:0]                   turn_nxt
);
  import mft_pkg::*;

  logic signed [16:0] diff;
  logic [15:0]        base;

  assign diff = $signed({1'b0, req.new_enc}) - $signed({1'b0, req.prev_enc});
  assign base = req.warmup_clear ? 16'd0 : req.turn;

  always_comb begin
    if (diff >= HALF_TURN_POS) begin
      turn_nxt = base - 16'd1;
    end else if (diff <= HALF_TURN_NEG) begin
      turn_nxt = base + 16'd1;
    end else begin
      turn_nxt = base;
    end
  end

endmodule
`default_nettype wire

### sv/motor_feedback_multiturn_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker
// Decodes motor feedback frames and time ticks into a status beat per item,
// with multiturn encoder unwrap and an offline timeout.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  in_      | sink      | command, 64-bit frame word
//  out_     | source    | temperature, current, speed, encoder, turns, status
//  cfg_     | sink      | 2-bit register index, 16-bit write data
//
// Each accepted item updates the tracker state in the cycle it is taken; the
// status registers are the result beat and show it from the next cycle on.
// One item per cycle is sustained while the output side takes beats.
// A stalled output beat blocks input; a new item is taken in the same cycle
// the waiting beat leaves. The configuration port is always ready.
// Synchronous active-low reset clears all state and loads register defaults.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_tracker (
  input  wire                logic        clk,
  input  wire                logic        rst_n,

  input  wire                logic        in_valid,
  output                     logic        in_ready,
  input  wire                logic        in_command,
  input  wire                logic [63:0] in_frame_word,

  output                     logic        out_valid,
  input  wire                logic        out_ready,
  output                     logic signed [7:0]  out_temperature,
  output                     logic signed [15:0] out_phase_current,
  output                     logic signed [15:0] out_speed,
  output                     logic [15:0] out_encoder,
  output                     logic signed [15:0] out_turn_count,
  output                     logic signed [31:0] out_total_position,
  output                     logic [7:0]  out_error_code,
  output                     logic        out_online,
  output                     logic [31:0] out_frames_received,

  input  wire                logic        cfg_valid,
  output                     logic        cfg_ready,
  input  wire                logic [1:0]  cfg_index,
  input  wire                logic [15:0] cfg_data
);
  import mft_pkg::*;

  logic [7:0]  cur_code_r;
  logic [7:0]  err_code_r;
  logic [15:0] timeout_r;

  logic [31:0] rx_count_r,  rx_count_nxt;
  logic [15:0] enc_r,       enc_nxt;
  logic [15:0] turn_r,      turn_nxt;
  logic [7:0]  temp_r,      temp_nxt;
  logic [15:0] current_r,   current_nxt;
  logic [15:0] speed_r,     speed_nxt;
  logic [7:0]  error_r,     error_nxt;
  logic [31:0] elapsed_r,   elapsed_nxt;
  logic        ever_r,      ever_nxt;
  logic        online_r,    online_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic            in_fire;
  logic            is_cur;
  logic            is_err;
  logic [31:0]     rx_count_inc;
  logic [15:0]     unwrap_turn;
  mft_unwrap_req_t unwrap_req;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_code_r <= RST_CURRENT_MODE;
      err_code_r <= RST_READ_ERROR;
      timeout_r  <= RST_OFFLINE_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CURRENT_MODE:    cur_code_r <= cfg_data[7:0];
        CFG_READ_ERROR:      err_code_r <= cfg_data[7:0];
        CFG_OFFLINE_TIMEOUT: timeout_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_cur = (in_frame_word[7:0] == cur_code_r);
  assign is_err = !is_cur && (in_frame_word[7:0] == err_code_r);

  // Frame count as it stands once this frame is counted; it also gates warm-up.
  assign rx_count_inc = (rx_count_r != '1) ? rx_count_r + 32'd1 : rx_count_r;

  assign unwrap_req.warmup_clear = (rx_count_inc < WARMUP_FRAMES);
  assign unwrap_req.turn         = turn_r;
  assign unwrap_req.prev_enc     = enc_r;
  assign unwrap_req.new_enc      = in_frame_word[63:48];

  mft_unwrap u_unwrap (
    .req      (unwrap_req),
    .turn_nxt (unwrap_turn)
  );

  always_comb begin
    rx_count_nxt  = rx_count_r;
    enc_nxt       = enc_r;
    turn_nxt      = turn_r;
    temp_nxt      = temp_r;
    current_nxt   = current_r;
    speed_nxt     = speed_r;
    error_nxt     = error_r;
    elapsed_nxt   = elapsed_r;
    ever_nxt      = ever_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      if (in_command == CMD_TICK) begin
        if (elapsed_r != '1) begin
          elapsed_nxt = elapsed_r + 32'd1;
        end
      end else begin
        rx_count_nxt = rx_count_inc;
        elapsed_nxt  = '0;
        ever_nxt     = 1'b1;
        if (is_cur) begin
          temp_nxt    = in_frame_word[15:8];
          current_nxt = in_frame_word[31:16];
          speed_nxt   = in_frame_word[47:32];
          enc_nxt     = in_frame_word[63:48];
          turn_nxt    = unwrap_turn;
        end else if (is_err) begin
          temp_nxt  = in_frame_word[15:8];
          error_nxt = in_frame_word[63:56];
        end
      end
    end

    online_nxt = ever_nxt && (elapsed_nxt <= {16'd0, timeout_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r  <= '0;
      enc_r       <= '0;
      turn_r      <= '0;
      temp_r      <= '0;
      current_r   <= '0;
      speed_r     <= '0;
      error_r     <= '0;
      elapsed_r   <= '0;
      ever_r      <= 1'b0;
      online_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_count_r  <= rx_count_nxt;
      enc_r       <= enc_nxt;
      turn_r      <= turn_nxt;
      temp_r      <= temp_nxt;
      current_r   <= current_nxt;
      speed_r     <= speed_nxt;
      error_r     <= error_nxt;
      elapsed_r   <= elapsed_nxt;
      ever_r      <= ever_nxt;
      online_r    <= online_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The state only moves when the waiting beat leaves, so it is the result beat.
  assign out_valid          = out_valid_r;
  assign out_temperature    = $signed(temp_r);
  assign out_phase_current  = $signed(current_r);
  assign out_speed          = $signed(speed_r);
  assign out_encoder        = enc_r;
  assign out_turn_count     = $signed(turn_r);
  assign out_total_position = $signed({turn_r, enc_r});
  assign out_error_code     = error_r;
  assign out_online         = online_r;
  assign out_frames_received = rx_count_r;

  a_frame_sets_online: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_command == CMD_FRAME) |=> (out_online && out_valid))
    else $error("frame beat did not produce an online result");

  a_tick_keeps_turns: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_command == CMD_TICK) |=> ($stable(out_turn_count) && $stable(out_encoder)))
    else $error("tick changed the position state");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (out_frames_received >= $past(out_frames_received)))
    else $error("frame count went backwards");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> ($stable(out_frames_received) && $stable(out_turn_count)))
    else $error("state changed without an accepted item");

endmodule
`default_nettype wire
